// ===== rtl/core/mva_pkg.sv =====
package mva_pkg;

    // input operation codes
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_CTRL     = 2'd2;
    localparam logic [1:0] OP_EXPIRY   = 2'd3;

    // result action codes
    localparam logic [3:0] ACT_FILTERED    = 4'd0;
    localparam logic [3:0] ACT_NO_FREE     = 4'd1;
    localparam logic [3:0] ACT_NOT_PLAYING = 4'd2;
    localparam logic [3:0] ACT_TO_VOICE    = 4'd3;
    localparam logic [3:0] ACT_BROADCAST   = 4'd4;
    localparam logic [3:0] ACT_ALL_OFF     = 4'd5;
    localparam logic [3:0] ACT_KEPT        = 4'd6;
    localparam logic [3:0] ACT_EXPIRED     = 4'd7;
    localparam logic [3:0] ACT_IDLE        = 4'd8;

    // controllers that silence every voice
    localparam logic [6:0] CTRL_ALL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CTRL_ALL_NOTES_OFF = 7'd123;

    // register map, byte address is 4 * index
    localparam int unsigned CFG_AW = 5;
    localparam logic [2:0] REG_CHANNEL_SELECT = 3'd0;
    localparam logic [2:0] REG_LOWEST_NOTE    = 3'd1;
    localparam logic [2:0] REG_HIGHEST_NOTE   = 3'd2;
    localparam logic [2:0] REG_SILENCE_LIMIT  = 3'd3;
    localparam logic [2:0] REG_PLAY_LIMIT     = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  ctrl_number;
        logic [6:0]  value;
        logic [3:0]  check_voice;
        logic [31:0] silent_ms;
        logic [31:0] active_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  action;
        logic [3:0]  voice;
        logic        newly_claimed;
        logic [6:0]  out_note;
        logic [6:0]  out_value;
        logic [15:0] active_mask;
    } t_out_item;

    typedef struct packed {
        logic [4:0]  channel_select;
        logic [6:0]  lowest_note;
        logic [6:0]  highest_note;
        logic [31:0] silence_limit_ms;
        logic [31:0] play_limit_ms;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic scan_start;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/core/midi_voice_allocator.sv =====
// Polyphonic voice allocator for MIDI note-on, note-off and controller events plus
// per-voice expiry checks; one result transaction per input transaction, in order. A note
// event that passes the channel and note filters goes through decode, a scan of the per-voice
// note memory at one voice per cycle and finish before the next transaction is accepted;
// filtered note events, controller events and expiry checks skip the scan. The result waits
// in an output register; a held result delays only the next item's commit. No clearing pass
// follows reset. Configuration registers sit on the APB port at byte address 4 * index; the
// user must write them only while the block is idle, which the block does not enforce.
module midi_voice_allocator #(
    parameter int unsigned NUM_VOICES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  mva_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output mva_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mva_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    mva_pkg::t_cfg    cfg;
    mva_pkg::t_cmd    cmd;
    mva_pkg::t_status status;

    mva_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mva_datapath #(
        .NUM_VOICES (NUM_VOICES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/mva_cfg_regs.sv =====
module mva_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mva_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output mva_pkg::t_cfg              o_cfg
);

    mva_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_select   <= 5'd0;
            r_cfg.lowest_note      <= 7'd0;
            r_cfg.highest_note     <= 7'd127;
            r_cfg.silence_limit_ms <= 32'd100;
            r_cfg.play_limit_ms    <= 32'd60000;
        end else if (wr_en) begin
            case (reg_idx)
                mva_pkg::REG_CHANNEL_SELECT: r_cfg.channel_select   <= pwdata[4:0];
                mva_pkg::REG_LOWEST_NOTE:    r_cfg.lowest_note      <= pwdata[6:0];
                mva_pkg::REG_HIGHEST_NOTE:   r_cfg.highest_note     <= pwdata[6:0];
                mva_pkg::REG_SILENCE_LIMIT:  r_cfg.silence_limit_ms <= pwdata;
                mva_pkg::REG_PLAY_LIMIT:     r_cfg.play_limit_ms    <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            mva_pkg::REG_CHANNEL_SELECT: prdata = {27'd0, r_cfg.channel_select};
            mva_pkg::REG_LOWEST_NOTE:    prdata = {25'd0, r_cfg.lowest_note};
            mva_pkg::REG_HIGHEST_NOTE:   prdata = {25'd0, r_cfg.highest_note};
            mva_pkg::REG_SILENCE_LIMIT:  prdata = r_cfg.silence_limit_ms;
            mva_pkg::REG_PLAY_LIMIT:     prdata = r_cfg.play_limit_ms;
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/mva_ctrl.sv =====
module mva_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  mva_pkg::t_status i_status,
    output mva_pkg::t_cmd    o_cmd
);

    mva_pkg::t_state r_state;
    mva_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mva_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            mva_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mva_pkg::ST_DECODE;
                end
            end
            mva_pkg::ST_DECODE: begin
                o_cmd.fetch = 1'b1;
                if (i_status.need_scan) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = mva_pkg::ST_SCAN;
                end else begin
                    n_state = mva_pkg::ST_FINISH;
                end
            end
            mva_pkg::ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = mva_pkg::ST_FINISH;
                end
            end
            mva_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = mva_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mva_pkg::ST_IDLE;
            end
        endcase
    end

    // scan completion only comes while scanning
    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.scan_done |-> r_state == mva_pkg::ST_SCAN)
        else $error("scan done outside scan state");

    // a result is written only into a free output slot
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_status.out_free)
        else $error("commit while output slot busy");

    // an accepted transaction always moves to decode
    a_load_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == mva_pkg::ST_DECODE)
        else $error("load not followed by decode");

endmodule

// ===== rtl/core/mva_datapath.sv =====
module mva_datapath #(
    parameter int unsigned NUM_VOICES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mva_pkg::t_cfg      i_cfg,
    input  mva_pkg::t_in_item  i_in_data,
    input  mva_pkg::t_cmd      i_cmd,
    output mva_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mva_pkg::t_out_item o_out_data
);

    localparam int unsigned IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int unsigned MW = (NUM_VOICES > 16) ? NUM_VOICES : 16;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_VOICES - 1);

    mva_pkg::t_in_item  r_item;
    mva_pkg::t_out_item r_out;
    mva_pkg::t_out_item n_out;
    logic               r_out_vld;

    logic [NUM_VOICES-1:0] r_busy;
    logic [NUM_VOICES-1:0] n_busy;
    logic [6:0]            r_note_mem [NUM_VOICES];

    // scan and read port
    logic          r_issue;
    logic [IW-1:0] r_scan_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [6:0]    r_rd_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic          r_match_found;
    logic [IW-1:0] r_match_idx;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;

    logic          chan_ok;
    logic          note_pass;
    logic          all_off;
    logic          cv_in_range;
    logic [IW-1:0] cv_addr;
    logic          exceeded;
    logic          mem_we;
    logic [MW-1:0] busy_pad;

    // event filters
    assign chan_ok     = (i_cfg.channel_select == 5'd0) ||
                         (i_cfg.channel_select == (5'(r_item.channel) + 5'd1));
    assign note_pass   = chan_ok && (r_item.note >= i_cfg.lowest_note) &&
                         (r_item.note <= i_cfg.highest_note);
    assign all_off     = (r_item.ctrl_number == mva_pkg::CTRL_ALL_SOUND_OFF) ||
                         (r_item.ctrl_number == mva_pkg::CTRL_ALL_NOTES_OFF);
    assign cv_in_range = 32'(r_item.check_voice) < 32'(NUM_VOICES);
    assign cv_addr     = IW'(r_item.check_voice);
    assign exceeded    = (r_item.silent_ms > i_cfg.silence_limit_ms) ||
                         (r_item.active_ms > i_cfg.play_limit_ms);

    assign o_status.need_scan = ((r_item.op == mva_pkg::OP_NOTE_ON) ||
                                 (r_item.op == mva_pkg::OP_NOTE_OFF)) && note_pass;
    assign o_status.scan_done = r_rd_vld && (r_rd_idx == LAST_IDX);
    assign o_status.out_free  = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
    end

    // scan address counter, one voice per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue    <= 1'b0;
            r_scan_idx <= '0;
        end else if (i_cmd.scan_start) begin
            r_issue    <= 1'b1;
            r_scan_idx <= '0;
        end else if (r_issue) begin
            if (r_scan_idx == LAST_IDX) begin
                r_issue <= 1'b0;
            end else begin
                r_scan_idx <= r_scan_idx + IW'(1);
            end
        end
    end

    assign rd_en   = r_issue || i_cmd.fetch;
    assign rd_addr = r_issue ? r_scan_idx : cv_addr;

    // note memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && mem_we) begin
            r_note_mem[r_free_idx] <= r_item.note;
        end
        if (rd_en) begin
            r_rd_data <= r_note_mem[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_issue;
        end
    end

    // lowest matching voice and lowest free voice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_match_idx   <= '0;
            r_free_idx    <= '0;
        end else if (i_cmd.scan_start) begin
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else if (r_rd_vld) begin
            if (!r_match_found && r_busy[r_rd_idx] && (r_rd_data == r_item.note)) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_rd_idx;
            end
            if (!r_free_found && !r_busy[r_rd_idx]) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
        end
    end

    // result and next voice state
    always_comb begin
        n_busy = r_busy;
        n_out  = '0;
        mem_we = 1'b0;
        case (r_item.op)
            mva_pkg::OP_NOTE_ON, mva_pkg::OP_NOTE_OFF: begin
                n_out.out_note  = r_item.note;
                n_out.out_value = r_item.value;
                if (!note_pass) begin
                    n_out.action = mva_pkg::ACT_FILTERED;
                end else if (r_match_found) begin
                    n_out.action = mva_pkg::ACT_TO_VOICE;
                    n_out.voice  = 4'(r_match_idx);
                end else if (r_item.op == mva_pkg::OP_NOTE_OFF) begin
                    n_out.action = mva_pkg::ACT_NOT_PLAYING;
                end else if (!r_free_found) begin
                    n_out.action = mva_pkg::ACT_NO_FREE;
                end else begin
                    n_busy[r_free_idx]  = 1'b1;
                    mem_we              = 1'b1;
                    n_out.action        = mva_pkg::ACT_TO_VOICE;
                    n_out.voice         = 4'(r_free_idx);
                    n_out.newly_claimed = 1'b1;
                end
            end
            mva_pkg::OP_CTRL: begin
                n_out.out_note  = r_item.ctrl_number;
                n_out.out_value = r_item.value;
                if (!chan_ok) begin
                    n_out.action = mva_pkg::ACT_FILTERED;
                end else if (all_off) begin
                    n_busy       = '0;
                    n_out.action = mva_pkg::ACT_ALL_OFF;
                end else begin
                    n_out.action = mva_pkg::ACT_BROADCAST;
                end
            end
            default: begin
                n_out.voice = r_item.check_voice;
                if (!cv_in_range || !r_busy[cv_addr]) begin
                    n_out.action = mva_pkg::ACT_IDLE;
                end else begin
                    n_out.out_note = r_rd_data;
                    if (exceeded) begin
                        n_busy[cv_addr] = 1'b0;
                        n_out.action    = mva_pkg::ACT_EXPIRED;
                    end else begin
                        n_out.action = mva_pkg::ACT_KEPT;
                    end
                end
            end
        endcase
        busy_pad          = MW'(n_busy);
        n_out.active_mask = busy_pad[15:0];
    end

    // voice busy flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_cmd.commit) begin
            r_busy <= n_busy;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // all-off leaves every voice free
    a_all_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_item.op == mva_pkg::OP_CTRL) && chan_ok && all_off)
        |=> (r_busy == '0))
        else $error("all-off left a voice busy");

    // a new result only appears after a commit
    a_out_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(i_cmd.commit))
        else $error("output valid without commit");

    // a claimed voice was free before the claim
    a_claim_was_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && mem_we) |-> !r_busy[r_free_idx])
        else $error("claimed a busy voice");

endmodule

// ===== tb/sv/midi_voice_allocator_tb.sv =====
module midi_voice_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV          = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int CFG_SETTLE  = 4;
    localparam int END_CYCLES  = 40;

    typedef enum logic {
        ROW_EVENT,
        ROW_REG
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [2:0]         reg_idx;
        logic [31:0]        reg_data;
        mva_pkg::t_in_item  item;
        logic               fixed;
        mva_pkg::t_out_item want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    mva_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    mva_pkg::t_out_item o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [mva_pkg::CFG_AW-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // shadow of the allocator: register settings and per-voice state
    mva_pkg::t_cfg      cfg_shadow;
    logic               voice_on  [NV];
    logic [6:0]         voice_key [NV];

    mva_pkg::t_out_item pending_routes[$];
    t_row               directed_rows[$];

    int          mismatches;
    int          cycle_count;
    int          hold_req;
    int          burst_left;
    int          send_quiet;
    int          recv_quiet;

    midi_voice_allocator #(
        .NUM_VOICES(NV)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // route one event through the shadow voice table, returns the expected result
    function automatic mva_pkg::t_out_item route_event(mva_pkg::t_in_item ev);
        mva_pkg::t_out_item res;
        int        hit;
        int        slot;
        int        v;
        logic      ch_ok;
        logic      in_window;
        res = '0;
        hit = -1;
        slot = -1;
        ch_ok = (cfg_shadow.channel_select == 5'd0) ||
                ({1'b0, ev.channel} == cfg_shadow.channel_select - 5'd1);
        in_window = (ev.note >= cfg_shadow.lowest_note) &&
                    (ev.note <= cfg_shadow.highest_note);
        case (ev.op)
            mva_pkg::OP_NOTE_ON, mva_pkg::OP_NOTE_OFF: begin
                res.out_note  = ev.note;
                res.out_value = ev.value;
                // lowest active voice on this note, lowest free voice
                for (v = NV - 1; v >= 0; v--) begin
                    if (voice_on[v] && voice_key[v] == ev.note) hit = v;
                    if (!voice_on[v]) slot = v;
                end
                if (!ch_ok || !in_window) begin
                    res.action = mva_pkg::ACT_FILTERED;
                end else if (hit >= 0) begin
                    res.action = mva_pkg::ACT_TO_VOICE;
                    res.voice  = 4'(hit);
                end else if (ev.op == mva_pkg::OP_NOTE_OFF) begin
                    res.action = mva_pkg::ACT_NOT_PLAYING;
                end else if (slot < 0) begin
                    res.action = mva_pkg::ACT_NO_FREE;
                end else begin
                    voice_on[slot]    = 1'b1;
                    voice_key[slot]   = ev.note;
                    res.action        = mva_pkg::ACT_TO_VOICE;
                    res.voice         = 4'(slot);
                    res.newly_claimed = 1'b1;
                end
            end
            mva_pkg::OP_CTRL: begin
                res.out_note  = ev.ctrl_number;
                res.out_value = ev.value;
                if (!ch_ok) begin
                    res.action = mva_pkg::ACT_FILTERED;
                end else if (ev.ctrl_number == mva_pkg::CTRL_ALL_SOUND_OFF ||
                             ev.ctrl_number == mva_pkg::CTRL_ALL_NOTES_OFF) begin
                    for (v = 0; v < NV; v++) voice_on[v] = 1'b0;
                    res.action = mva_pkg::ACT_ALL_OFF;
                end else begin
                    res.action = mva_pkg::ACT_BROADCAST;
                end
            end
            default: begin
                // expiry check, strictly greater on either limit frees the voice
                res.voice = ev.check_voice;
                if (!voice_on[ev.check_voice]) begin
                    res.action = mva_pkg::ACT_IDLE;
                end else begin
                    res.out_note = voice_key[ev.check_voice];
                    if (ev.silent_ms > cfg_shadow.silence_limit_ms ||
                        ev.active_ms > cfg_shadow.play_limit_ms) begin
                        voice_on[ev.check_voice] = 1'b0;
                        res.action = mva_pkg::ACT_EXPIRED;
                    end else begin
                        res.action = mva_pkg::ACT_KEPT;
                    end
                end
            end
        endcase
        for (v = 0; v < NV; v++) res.active_mask[v] = voice_on[v];
        return res;
    endfunction

    // wait length for one transaction, with occasional runs of no waiting
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet = $urandom_range(20, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // times around a limit
    function automatic logic [31:0] near_limit(logic [31:0] lim);
        case ($urandom_range(0, 5))
            0: return lim;
            1: return lim + 32'd1;
            2: return lim - 32'd1;
            3: return '0;
            4: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic mva_pkg::t_in_item mk_event(logic [1:0] op, int ch, int note, int ctrl,
                                                   int val, int cv, logic [31:0] sil,
                                                   logic [31:0] act);
        mva_pkg::t_in_item ev;
        ev.op          = op;
        ev.channel     = 4'(ch);
        ev.note        = 7'(note);
        ev.ctrl_number = 7'(ctrl);
        ev.value       = 7'(val);
        ev.check_voice = 4'(cv);
        ev.silent_ms   = sil;
        ev.active_ms   = act;
        return ev;
    endfunction

    function automatic mva_pkg::t_out_item mk_route(logic [3:0] action, int voice, int fresh,
                                                    int note, int val, logic [15:0] mask);
        mva_pkg::t_out_item r;
        r.action        = action;
        r.voice         = 4'(voice);
        r.newly_claimed = 1'(fresh);
        r.out_note      = 7'(note);
        r.out_value     = 7'(val);
        r.active_mask   = mask;
        return r;
    endfunction

    function automatic t_row ev_row(mva_pkg::t_in_item ev, logic fixed,
                                    mva_pkg::t_out_item want);
        t_row row;
        row.kind     = ROW_EVENT;
        row.reg_idx  = '0;
        row.reg_data = '0;
        row.item     = ev;
        row.fixed    = fixed;
        row.want     = want;
        return row;
    endfunction

    function automatic t_row reg_row(logic [2:0] idx, logic [31:0] data);
        t_row row;
        row.kind     = ROW_REG;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.item     = '0;
        row.fixed    = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    // append one row to the directed table
    function automatic void add_row(t_row row);
        directed_rows = {directed_rows, row};
    endfunction

    // append one expected result
    function automatic void queue_result(mva_pkg::t_out_item r);
        pending_routes = {pending_routes, r};
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // one input transaction, prediction taken at acceptance
    task automatic send_event(mva_pkg::t_in_item ev, logic fixed, mva_pkg::t_out_item want);
        int gap;
        gap = draw_wait(send_quiet);
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        if (fixed) begin
            void'(route_event(ev));
            queue_result(want);
        end else begin
            queue_result(route_event(ev));
        end
    endtask

    // stop offering and wait until every result is out
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    // apb write, setup then access, then idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mva_pkg::REG_CHANNEL_SELECT: cfg_shadow.channel_select   = data[4:0];
            mva_pkg::REG_LOWEST_NOTE:    cfg_shadow.lowest_note      = data[6:0];
            mva_pkg::REG_HIGHEST_NOTE:   cfg_shadow.highest_note     = data[6:0];
            mva_pkg::REG_SILENCE_LIMIT:  cfg_shadow.silence_limit_ms = data;
            mva_pkg::REG_PLAY_LIMIT:     cfg_shadow.play_limit_ms    = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [4:0] cs, logic [6:0] lo, logic [6:0] hi,
                                 logic [31:0] sil, logic [31:0] play);
        settle_idle();
        write_reg(mva_pkg::REG_CHANNEL_SELECT, 32'(cs));
        write_reg(mva_pkg::REG_LOWEST_NOTE, 32'(lo));
        write_reg(mva_pkg::REG_HIGHEST_NOTE, 32'(hi));
        write_reg(mva_pkg::REG_SILENCE_LIMIT, sil);
        write_reg(mva_pkg::REG_PLAY_LIMIT, play);
    endtask

    // result side: random stalls, check each accepted transaction
    initial begin
        int                 n;
        mva_pkg::t_out_item want;
        mva_pkg::t_out_item got;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
            end else begin
                n = draw_wait(recv_quiet);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got = o_out_data;
            if (pending_routes.size() == 0) begin
                $display("%0t: unexpected result, got %p", $time, got);
                mismatches++;
            end else begin
                want = pending_routes.pop_front();
                check_field("action", 32'(want.action), 32'(got.action));
                check_field("voice", 32'(want.voice), 32'(got.voice));
                check_field("newly_claimed", 32'(want.newly_claimed), 32'(got.newly_claimed));
                check_field("out_note", 32'(want.out_note), 32'(got.out_note));
                check_field("out_value", 32'(want.out_value), 32'(got.out_value));
                check_field("active_mask", 32'(want.active_mask), 32'(got.active_mask));
            end
        end
    end

    // stimulus
    initial begin
        mva_pkg::t_in_item ev;
        int          ph;
        int          n;
        int          k;
        int          slot;
        int          chord_left;
        int          phase_len;
        logic [4:0]  cs;
        logic [6:0]  lo;
        logic [6:0]  hi;
        logic [31:0] sil;
        logic [31:0] play;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mismatches = 0;
        hold_req   = 0;
        burst_left = 0;
        send_quiet = 0;
        recv_quiet = 0;
        chord_left = 0;
        cfg_shadow.channel_select   = 5'd0;
        cfg_shadow.lowest_note      = 7'd0;
        cfg_shadow.highest_note     = 7'd127;
        cfg_shadow.silence_limit_ms = 32'd100;
        cfg_shadow.play_limit_ms    = 32'd60000;
        for (n = 0; n < NV; n++) begin
            voice_on[n]  = 1'b0;
            voice_key[n] = 7'd0;
        end

        // directed rows, fixed results where obvious, else from the shadow
        add_row(ev_row(mk_event(mva_pkg::OP_EXPIRY, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_IDLE, 0, 0, 0, 0, 16'h0000)));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 0, 0, 0, 127, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_TO_VOICE, 0, 1, 0, 127, 16'h0001)));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 15, 127, 0, 0, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_TO_VOICE, 1, 1, 127, 0, 16'h0003)));
        // same note again reuses its voice
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 3, 0, 0, 5, 0, 0, 0), 1'b0, '0));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_OFF, 9, 127, 0, 64, 0, 0, 0), 1'b0, '0));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_OFF, 0, 60, 0, 0, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_NOT_PLAYING, 0, 0, 60, 0, 16'h0003)));
        add_row(ev_row(mk_event(mva_pkg::OP_CTRL, 0, 0, 7, 100, 0, 0, 0), 1'b0, '0));
        // limits compare strictly greater
        add_row(ev_row(mk_event(mva_pkg::OP_EXPIRY, 0, 0, 0, 0, 1, 100, 60000), 1'b1,
                       mk_route(mva_pkg::ACT_KEPT, 1, 0, 127, 0, 16'h0003)));
        add_row(ev_row(mk_event(mva_pkg::OP_EXPIRY, 0, 0, 0, 0, 1, 101, 0), 1'b1,
                       mk_route(mva_pkg::ACT_EXPIRED, 1, 0, 127, 0, 16'h0001)));
        add_row(ev_row(mk_event(mva_pkg::OP_EXPIRY, 0, 0, 0, 0, 0, 0, 60001), 1'b1,
                       mk_route(mva_pkg::ACT_EXPIRED, 0, 0, 0, 0, 16'h0000)));
        add_row(ev_row(mk_event(mva_pkg::OP_EXPIRY, 0, 0, 0, 0, 15, '1, '1), 1'b1,
                       mk_route(mva_pkg::ACT_IDLE, 15, 0, 0, 0, 16'h0000)));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 0, 64, 0, 1, 0, 0, 0), 1'b0, '0));
        add_row(ev_row(mk_event(mva_pkg::OP_CTRL, 0, 0, 123, 0, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_ALL_OFF, 0, 0, 123, 0, 16'h0000)));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 0, 64, 0, 1, 0, 0, 0), 1'b0, '0));
        add_row(ev_row(mk_event(mva_pkg::OP_CTRL, 0, 0, 120, 127, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_ALL_OFF, 0, 0, 120, 127, 16'h0000)));
        // one channel, narrow note window
        add_row(reg_row(mva_pkg::REG_CHANNEL_SELECT, 32'd5));
        add_row(reg_row(mva_pkg::REG_LOWEST_NOTE, 32'd10));
        add_row(reg_row(mva_pkg::REG_HIGHEST_NOTE, 32'd20));
        add_row(reg_row(mva_pkg::REG_SILENCE_LIMIT, 32'd0));
        add_row(reg_row(mva_pkg::REG_PLAY_LIMIT, 32'hFFFF_FFFF));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 3, 15, 0, 2, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_FILTERED, 0, 0, 15, 2, 16'h0000)));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 4, 9, 0, 2, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_FILTERED, 0, 0, 9, 2, 16'h0000)));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 4, 21, 0, 2, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_FILTERED, 0, 0, 21, 2, 16'h0000)));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 4, 10, 0, 3, 0, 0, 0), 1'b0, '0));
        add_row(ev_row(mk_event(mva_pkg::OP_CTRL, 5, 0, 120, 0, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_FILTERED, 0, 0, 120, 0, 16'h0001)));
        add_row(ev_row(mk_event(mva_pkg::OP_EXPIRY, 0, 0, 0, 0, 0, 1, 0), 1'b1,
                       mk_route(mva_pkg::ACT_EXPIRED, 0, 0, 10, 0, 16'h0000)));
        // inverted note window: notes filtered, controllers still pass
        add_row(reg_row(mva_pkg::REG_CHANNEL_SELECT, 32'd0));
        add_row(reg_row(mva_pkg::REG_LOWEST_NOTE, 32'd100));
        add_row(reg_row(mva_pkg::REG_HIGHEST_NOTE, 32'd50));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 0, 75, 0, 9, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_FILTERED, 0, 0, 75, 9, 16'h0000)));
        add_row(ev_row(mk_event(mva_pkg::OP_CTRL, 0, 0, 121, 9, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_BROADCAST, 0, 0, 121, 9, 16'h0000)));
        // channel select above 16 matches nothing, then 16 selects channel 15
        add_row(reg_row(mva_pkg::REG_CHANNEL_SELECT, 32'd31));
        add_row(reg_row(mva_pkg::REG_LOWEST_NOTE, 32'd0));
        add_row(reg_row(mva_pkg::REG_HIGHEST_NOTE, 32'd127));
        add_row(reg_row(mva_pkg::REG_SILENCE_LIMIT, 32'hFFFF_FFFF));
        add_row(reg_row(mva_pkg::REG_PLAY_LIMIT, 32'd0));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 15, 127, 0, 127, 0, 0, 0), 1'b1,
                       mk_route(mva_pkg::ACT_FILTERED, 0, 0, 127, 127, 16'h0000)));
        add_row(reg_row(mva_pkg::REG_CHANNEL_SELECT, 32'd16));
        add_row(ev_row(mk_event(mva_pkg::OP_NOTE_ON, 15, 0, 0, 127, 0, 0, 0), 1'b0, '0));
        add_row(ev_row(mk_event(mva_pkg::OP_EXPIRY, 0, 0, 0, 0, 0, '1, 1), 1'b1,
                       mk_route(mva_pkg::ACT_EXPIRED, 0, 0, 0, 0, 16'h0000)));

        // reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                settle_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
            end else begin
                send_event(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
            end
        end

        // random phases, each with its own register setting
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    cs = 5'd0; lo = 7'd0; hi = 7'd127;
                    sil = 32'd100; play = 32'd60000; phase_len = 250;
                end
                1: begin
                    cs = 5'($urandom_range(1, 16));
                    lo = 7'($urandom_range(0, 40));
                    hi = 7'($urandom_range(60, 127));
                    sil = 32'($urandom_range(0, 5000)); play = $urandom; phase_len = 250;
                end
                2: begin
                    cs = 5'd0; lo = 7'($urandom_range(0, 127)); hi = lo;
                    sil = '0; play = '0; phase_len = 200;
                end
                3: begin
                    cs = 5'd16; lo = 7'd0; hi = 7'd127;
                    sil = '1; play = '1; phase_len = 250;
                end
                4: begin
                    // every note and controller event filtered by channel
                    cs = 5'($urandom_range(17, 31)); lo = 7'd0; hi = 7'd127;
                    sil = $urandom; play = $urandom; phase_len = 30;
                end
                5: begin
                    // inverted note window
                    cs = 5'd0; lo = 7'($urandom_range(64, 127)); hi = 7'($urandom_range(0, 63));
                    sil = $urandom; play = $urandom; phase_len = 30;
                end
                default: begin
                    cs = 5'($urandom_range(0, 16));
                    lo = 7'($urandom_range(0, 60));
                    hi = 7'($urandom_range(lo, 127));
                    sil = near_limit(32'd1000); play = near_limit(32'd60000); phase_len = 300;
                end
            endcase
            apply_setting(cs, lo, hi, sil, play);

            // long result hold-off while the sender keeps going
            if (ph == 1) begin
                hold_req   = 400;
                burst_left = 40;
            end

            for (n = 0; n < phase_len; n++) begin
                // sender pause until everything has drained
                if (ph == 2 && n == phase_len / 2) settle_idle();

                ev.channel = 4'($urandom_range(0, 15));
                if (cfg_shadow.channel_select != 5'd0 && cfg_shadow.channel_select <= 5'd16 &&
                    $urandom_range(0, 7) != 0) begin
                    ev.channel = 4'(cfg_shadow.channel_select - 5'd1);
                end
                ev.ctrl_number = 7'($urandom_range(0, 127));
                k = $urandom_range(0, 31);
                if (k == 0) begin
                    ev.ctrl_number = mva_pkg::CTRL_ALL_SOUND_OFF;
                end else if (k == 1) begin
                    ev.ctrl_number = mva_pkg::CTRL_ALL_NOTES_OFF;
                end
                ev.value       = 7'($urandom_range(0, 127));
                ev.check_voice = 4'($urandom_range(0, NV - 1));
                ev.silent_ms   = near_limit(cfg_shadow.silence_limit_ms);
                ev.active_ms   = near_limit(cfg_shadow.play_limit_ms);

                // a playing note, a note in the window, or any note
                slot = $urandom_range(0, NV - 1);
                k = $urandom_range(0, 9);
                if (k < 4 && voice_on[slot]) begin
                    ev.note = voice_key[slot];
                end else if (k < 9 && cfg_shadow.lowest_note <= cfg_shadow.highest_note) begin
                    ev.note = 7'($urandom_range(cfg_shadow.lowest_note,
                                                cfg_shadow.highest_note));
                end else begin
                    ev.note = 7'($urandom_range(0, 127));
                end

                // chords of note-ons fill the voices up
                if (chord_left == 0 && $urandom_range(0, 11) == 0) begin
                    chord_left = $urandom_range(8, 20);
                end
                if (chord_left > 0) begin
                    ev.op = mva_pkg::OP_NOTE_ON;
                    chord_left--;
                end else begin
                    k = $urandom_range(0, 99);
                    if (k < 40) begin
                        ev.op = mva_pkg::OP_NOTE_ON;
                    end else if (k < 65) begin
                        ev.op = mva_pkg::OP_NOTE_OFF;
                    end else if (k < 80) begin
                        ev.op = mva_pkg::OP_CTRL;
                    end else begin
                        ev.op = mva_pkg::OP_EXPIRY;
                    end
                end
                send_event(ev, 1'b0, '0);
            end
        end

        // drain and let the block go quiet
        i_in_valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
